### hw/rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants of the Gaussian pyramid reduce block: field
// widths, register indexes and the column operation passed from front to back.
// ----------------------------------------------------------------------------
package gpr_pkg;

   localparam int PIXEL_W      = 16;   // input sample
   localparam int HV_W         = 20;   // horizontally filtered value, pixel * 16
   localparam int VAL_W        = 24;   // blurred value, pixel * 256
   localparam int ROW_W        = 9;    // out_row / out_col
   localparam int CFG_W        = 11;   // image_width / image_height
   localparam int CSR_INDEX_W  = 1;
   localparam int TAPS         = 5;
   localparam int LINE_BUFFERS = 4;
   localparam int BANK_W       = 2;
   localparam int MIN_DIM      = 6;
   localparam int PUSH_MAX     = 3;    // column operations caused by one item
   localparam int PUSH_W       = 2;
   localparam int QUEUE_DEPTH  = 8;
   localparam int QPTR_W       = 3;
   localparam int QCNT_W       = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // One column of one row: line buffer write plus the vertical pass.
   typedef struct packed {
      logic [HV_W-1:0]              hval;
      logic                         live;        // write hval to the line buffer
      logic [BANK_W-1:0]            wr_bank;
      logic                         emit;        // this column gives a result
      logic [ROW_W-1:0]             out_row;
      logic [ROW_W-1:0]             out_col;
      logic                         level_done;
      logic [TAPS-1:0]              tap_live;    // tap takes hval, not a buffer
      logic [TAPS-1:0][BANK_W-1:0]  tap_bank;
   } op_type;

endpackage

### hw/rtl/gpr_front.sv
// ----------------------------------------------------------------------------
// gpr_front
// Takes pixels, tracks the stream position, runs the horizontal 5-tap blur and
// turns each item into zero to three column operations for the back end.
// ----------------------------------------------------------------------------
module gpr_front #(
   parameter int W_CAP   = 1024,
   parameter int H_CAP   = 1024,
   parameter int W_RESET = 640,
   parameter int H_RESET = 480,
   parameter int COL_W   = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [gpr_pkg::PIXEL_W-1:0]         req_pixel,
   input  logic                                req_drain,
   input  logic                                csr_write_en,
   input  logic [gpr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpr_pkg::CFG_W-1:0]           csr_data,
   input  logic                                queue_room,
   output logic [gpr_pkg::PUSH_W-1:0]          push_count,
   output gpr_pkg::op_type                     push_op   [gpr_pkg::PUSH_MAX],
   output logic [COL_W-1:0]                    push_addr [gpr_pkg::PUSH_MAX]
);
   import gpr_pkg::*;

   localparam logic [CFG_W-1:0] W_CAP_V   = CFG_W'(W_CAP);
   localparam logic [CFG_W-1:0] H_CAP_V   = CFG_W'(H_CAP);
   localparam logic [CFG_W-1:0] W_RESET_V = CFG_W'(W_RESET);
   localparam logic [CFG_W-1:0] H_RESET_V = CFG_W'(H_RESET);
   localparam int               RS_W      = CFG_W + 2;

   typedef logic [TAPS-1:0][PIXEL_W-1:0] window_type;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [COL_W-1:0] col_count_ff;
   logic [CFG_W-1:0] row_count_ff;
   window_type       window_ff;
   window_type       window_in;

   window_type       win1, win2, win3;
   logic [HV_W-1:0]  hv        [PUSH_MAX];
   logic [COL_W-1:0] col_v     [PUSH_MAX];
   logic [PUSH_MAX-1:0] op_valid;
   op_type           op        [PUSH_MAX];
   logic [CFG_W-1:0] c_ext, last_row, last_col, h_last, r;
   logic signed [RS_W-1:0] rs;
   logic             live, take, act, row_end, big, row_ok;
   logic [TAPS-1:0]  tap_live;
   logic [TAPS-1:0][BANK_W-1:0] tap_bank;
   logic [PUSH_W-1:0] n;

   function automatic logic [HV_W-1:0] hsum(input window_type w);
      logic [HV_W-1:0] a0, a1, a2, a3, a4;
      a0 = HV_W'(w[0]);
      a1 = HV_W'(w[1]);
      a2 = HV_W'(w[2]);
      a3 = HV_W'(w[3]);
      a4 = HV_W'(w[4]);
      return a0 + (a1 << 2) + (a2 << 2) + (a2 << 1) + (a3 << 2) + a4;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] cap);
      logic [CFG_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = CFG_W'(1);
      end else if (v > cap) begin
         res = cap;
      end
      return res;
   endfunction

   always_comb begin
      live     = row_count_ff < height_ff;
      take     = req_valid && queue_room;
      act      = take && !(live && req_drain);   // drain inside the image is dropped
      c_ext    = CFG_W'(col_count_ff);
      row_end  = (c_ext >= width_ff - CFG_W'(1));
      big      = (width_ff >= CFG_W'(MIN_DIM)) && (height_ff >= CFG_W'(MIN_DIM));
      last_row = {height_ff[CFG_W-1:1], 1'b0};
      last_col = {width_ff[CFG_W-1:1], 1'b0} - CFG_W'(2);
      h_last   = height_ff - CFG_W'(1);
      row_ok   = big && (row_count_ff >= CFG_W'(2)) && !row_count_ff[0] &&
                 (row_count_ff <= last_row);

      // horizontal windows: after this pixel, and with it repeated as right edge replication (win2, win3)
      for (int k = 0; k < TAPS - 1; k++) begin
         win1[k] = (col_count_ff == '0) ? req_pixel : window_ff[k+1];
      end
      win1[TAPS-1] = req_pixel;
      for (int k = 0; k < TAPS - 1; k++) begin
         win2[k] = win1[k+1];
         win3[k] = win2[k+1];
      end
      win2[TAPS-1] = req_pixel;
      win3[TAPS-1] = req_pixel;

      window_in = window_ff;
      if (act && live) begin
         window_in = row_end ? win3 : win1;
      end

      hv[0] = live ? hsum(win1) : '0;
      hv[1] = live ? hsum(win2) : '0;
      hv[2] = live ? hsum(win3) : '0;

      col_v[0] = col_count_ff - COL_W'(2);
      col_v[1] = col_count_ff - COL_W'(1);
      col_v[2] = col_count_ff;
      op_valid[0] = c_ext >= CFG_W'(2);
      op_valid[1] = row_end && (c_ext >= CFG_W'(1));
      op_valid[2] = row_end;

      // vertical tap rows depend on the row only; clamp to the image
      for (int k = 0; k < TAPS; k++) begin
         rs = $signed({2'b00, row_count_ff}) + $signed(RS_W'(k))
              - $signed(RS_W'(TAPS - 1));
         if (rs < 0) begin
            r = '0;
         end else if (rs > $signed({2'b00, h_last})) begin
            r = h_last;
         end else begin
            r = rs[CFG_W-1:0];
         end
         tap_bank[k] = r[BANK_W-1:0];
         tap_live[k] = live && (r == row_count_ff);
      end

      for (int i = 0; i < PUSH_MAX; i++) begin
         op[i].hval       = hv[i];
         op[i].live       = live;
         op[i].wr_bank    = row_count_ff[BANK_W-1:0];
         op[i].emit       = row_ok && !col_v[i][0] && (CFG_W'(col_v[i]) <= last_col);
         op[i].out_row    = ROW_W'((row_count_ff - CFG_W'(2)) >> 1);
         op[i].out_col    = ROW_W'(col_v[i] >> 1);
         op[i].level_done = (row_count_ff == last_row) && (CFG_W'(col_v[i]) == last_col);
         op[i].tap_live   = tap_live;
         op[i].tap_bank   = tap_bank;
      end

      // pack the valid operations in column order
      n = '0;
      for (int i = 0; i < PUSH_MAX; i++) begin
         push_op[i]   = op[i];
         push_addr[i] = col_v[i];
      end
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (op_valid[i]) begin
            push_op[n]   = op[i];
            push_addr[n] = col_v[i];
            n = n + PUSH_W'(1);
         end
      end
      push_count = act ? n : '0;
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= W_RESET_V;
         height_ff    <= H_RESET_V;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (csr_write_en) begin
         // any register write restarts the frame
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff     <= clamp_dim(csr_data, W_CAP_V);
               col_count_ff <= '0;
               row_count_ff <= '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff    <= clamp_dim(csr_data, H_CAP_V);
               col_count_ff <= '0;
               row_count_ff <= '0;
            end
            default: begin
            end
         endcase
      end else if (act) begin
         if (row_end) begin
            col_count_ff <= '0;
            row_count_ff <= (row_count_ff >= last_row) ? '0 : row_count_ff + CFG_W'(1);
         end else begin
            col_count_ff <= col_count_ff + COL_W'(1);
         end
      end
   end

endmodule

### hw/rtl/gpr_queue.sv
// ----------------------------------------------------------------------------
// gpr_queue
// Short queue of column operations between front and back. Takes up to three
// entries per cycle and hands out one on each pop.
// ----------------------------------------------------------------------------
module gpr_queue #(
   parameter int ADDR_W = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gpr_pkg::PUSH_W-1:0]    push_count,
   input  gpr_pkg::op_type               push_op   [gpr_pkg::PUSH_MAX],
   input  logic [ADDR_W-1:0]             push_addr [gpr_pkg::PUSH_MAX],
   input  logic                          pop,
   output logic                          head_valid,
   output gpr_pkg::op_type               head_op,
   output logic [ADDR_W-1:0]             head_addr,
   output logic                          room
);
   import gpr_pkg::*;

   op_type            op_ff   [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head_valid = (count_ff != '0);
   assign head_op    = op_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];
   // room for the largest burst one item can cause
   assign room       = (count_ff <= QCNT_W'(QUEUE_DEPTH - PUSH_MAX));

   always_ff @(posedge clock) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (PUSH_W'(i) < push_count) begin
            op_ff[wr_ptr_ff + QPTR_W'(i)]   <= push_op[i];
            addr_ff[wr_ptr_ff + QPTR_W'(i)] <= push_addr[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
      end
   end

endmodule

### hw/rtl/gpr_line_store.sv
// ----------------------------------------------------------------------------
// gpr_line_store
// Four line buffers of horizontally filtered values, one per row modulo four.
// All banks read the same column; one bank may be written there. Read returns
// the value held before the write.
// ----------------------------------------------------------------------------
module gpr_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                               clock,
   input  logic                               access,
   input  logic [ADDR_W-1:0]                  addr,
   input  logic                               wr_en,
   input  logic [gpr_pkg::BANK_W-1:0]         wr_bank,
   input  logic [gpr_pkg::HV_W-1:0]           wr_data,
   output logic [gpr_pkg::HV_W-1:0]           rd_data [gpr_pkg::LINE_BUFFERS]
);
   import gpr_pkg::*;

   for (genvar b = 0; b < LINE_BUFFERS; b++) begin : g_bank
      logic [HV_W-1:0] mem [DEPTH];
      logic [HV_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (access) begin
            if (wr_en && (wr_bank == BANK_W'(b))) begin
               mem[addr] <= wr_data;
            end
            rd_ff <= mem[addr];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

### hw/rtl/gpr_back.sv
// ----------------------------------------------------------------------------
// gpr_back
// Executes column operations: line buffer access, then the vertical 5-tap
// blur into the result register.
// ----------------------------------------------------------------------------
module gpr_back #(
   parameter int ADDR_W = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  gpr_pkg::op_type               head_op,
   input  logic [ADDR_W-1:0]             head_addr,
   output logic                          pop,
   output logic                          mem_access,
   output logic [ADDR_W-1:0]             mem_addr,
   output logic                          mem_wr_en,
   output logic [gpr_pkg::BANK_W-1:0]    mem_wr_bank,
   output logic [gpr_pkg::HV_W-1:0]      mem_wr_data,
   input  logic [gpr_pkg::HV_W-1:0]      mem_rd_data [gpr_pkg::LINE_BUFFERS],
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gpr_pkg::VAL_W-1:0]     rsp_blurred_value,
   output logic [gpr_pkg::ROW_W-1:0]     rsp_out_row,
   output logic [gpr_pkg::ROW_W-1:0]     rsp_out_col,
   output logic                          rsp_level_done
);
   import gpr_pkg::*;

   op_type           op_ff;
   logic             a_valid_ff, a_valid_in;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] value_ff;
   logic [ROW_W-1:0] row_ff, col_ff;
   logic             done_ff;
   logic             out_free, a_adv;
   logic [VAL_W-1:0] tv [TAPS];
   logic [VAL_W-1:0] vsum;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      a_adv      = a_valid_ff && out_free;
      pop        = head_valid && (!a_valid_ff || out_free);
      a_valid_in = pop || (a_valid_ff && !out_free);

      mem_access  = pop;
      mem_addr    = head_addr;
      mem_wr_en   = pop && head_op.live;
      mem_wr_bank = head_op.wr_bank;
      mem_wr_data = head_op.hval;

      for (int k = 0; k < TAPS; k++) begin
         tv[k] = VAL_W'(op_ff.tap_live[k] ? op_ff.hval : mem_rd_data[op_ff.tap_bank[k]]);
      end
      // 1,4,6,4,1
      vsum = tv[0] + (tv[1] << 2) + (tv[2] << 2) + (tv[2] << 1) + (tv[3] << 2) + tv[4];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head_op;
      end
      if (a_adv) begin
         value_ff <= vsum;
         row_ff   <= op_ff.out_row;
         col_ff   <= op_ff.out_col;
         done_ff  <= op_ff.level_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (out_free) begin
            rsp_valid_ff <= a_valid_ff && op_ff.emit;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = value_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_level_done    = done_ff;

endmodule

### hw/rtl/gaussian_pyramid_reduce.sv
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce
// One Gaussian pyramid level: 5-tap binomial blur in both directions with
// edge replication, keeping even rows and columns. Results are pixel * 256.
//
//   channel  direction  ports                              transfer when
//   req      in         req_pixel, req_drain               req_valid & !req_stall
//   rsp      out        rsp_blurred_value, rsp_out_row,    rsp_valid & !rsp_stall
//                       rsp_out_col, rsp_level_done
//   csr      in         csr_index, csr_data                csr_write_en
//
// One pixel per clock sustained while rsp is not held. A result goes from the
// pixel that completes it through the op queue, line buffer read and result
// register. The last pixel of a row causes up to three column operations and
// the back end runs one per cycle unless rsp is held, so the second and third
// of them leave in turn; the 8-entry queue absorbs that burst, so req_stall
// rises only as a result of rsp being held. Reset is synchronous and clears the stream
// position and queue; the line buffers are not cleared.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gpr_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                              req_drain,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gpr_pkg::VAL_W-1:0]         rsp_blurred_value,
   output logic [gpr_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [gpr_pkg::ROW_W-1:0]         rsp_out_col,
   output logic                              rsp_level_done,
   input  logic                              csr_write_en,
   input  logic [gpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gpr_pkg::CFG_W-1:0]         csr_data
);
   import gpr_pkg::*;

   localparam int CFG_MAX = (1 << CFG_W) - 1;
   localparam int W_CAP   = (MAX_WIDTH  > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
   localparam int H_CAP   = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
   localparam int W_RESET = (W_CAP < 640) ? W_CAP : 640;
   localparam int H_RESET = (H_CAP < 480) ? H_CAP : 480;
   localparam int COL_W   = $clog2(W_CAP);

   logic [PUSH_W-1:0] push_count;
   op_type            push_op   [PUSH_MAX];
   logic [COL_W-1:0]  push_addr [PUSH_MAX];
   logic              queue_room;
   logic              head_valid;
   op_type            head_op;
   logic [COL_W-1:0]  head_addr;
   logic              pop;
   logic              mem_access;
   logic [COL_W-1:0]  mem_addr;
   logic              mem_wr_en;
   logic [BANK_W-1:0] mem_wr_bank;
   logic [HV_W-1:0]   mem_wr_data;
   logic [HV_W-1:0]   mem_rd_data [LINE_BUFFERS];

   assign req_stall = !queue_room;

   gpr_front #(
      .W_CAP   (W_CAP),
      .H_CAP   (H_CAP),
      .W_RESET (W_RESET),
      .H_RESET (H_RESET),
      .COL_W   (COL_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_pixel    (req_pixel),
      .req_drain    (req_drain),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_room   (queue_room),
      .push_count   (push_count),
      .push_op      (push_op),
      .push_addr    (push_addr)
   );

   gpr_queue #(
      .ADDR_W (COL_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_op    (push_op),
      .push_addr  (push_addr),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op),
      .head_addr  (head_addr),
      .room       (queue_room)
   );

   gpr_line_store #(
      .DEPTH  (W_CAP),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .access  (mem_access),
      .addr    (mem_addr),
      .wr_en   (mem_wr_en),
      .wr_bank (mem_wr_bank),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   gpr_back #(
      .ADDR_W (COL_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_op           (head_op),
      .head_addr         (head_addr),
      .pop               (pop),
      .mem_access        (mem_access),
      .mem_addr          (mem_addr),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_bank       (mem_wr_bank),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_data       (mem_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blurred_value (rsp_blurred_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_level_done    (rsp_level_done)
   );

endmodule
